FILE: src/stt_pkg.sv
// Package for the scaled timer table: op codes, result kinds, FSM states, command and status structs.
// No dependencies.
package stt_pkg;
    localparam int NUM_SLOTS_DEF = 16;
    localparam logic [23:0] MAX_DELTA_RST = 24'd100000;
    localparam logic [15:0] SCALE_ONE = 16'd256;

    typedef enum logic [3:0] {
        OP_TICK = 4'd0, OP_ADD = 4'd1, OP_CANCEL = 4'd2, OP_PAUSE = 4'd3,
        OP_RESUME = 4'd4, OP_STEP = 4'd5, OP_SET_SCALE = 4'd6,
        OP_SMOOTH = 4'd7, OP_CANCEL_SMOOTH = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        KIND_SUMMARY = 2'd0, KIND_FIRED = 2'd1, KIND_ACK = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_SCALE, ST_WALK, ST_SUMMARY, ST_ACK
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic start_op;   // latch input item, run op effects (tick budget and ramp update)
        logic div_step;   // one divider step
        logic scale_calc; // finish ramp, compute scaled delta
        logic walk_step;  // process current slot
        logic emit;       // load output register
        logic [1:0] kind;
        logic last;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic need_div;
        logic div_done;
        logic walk_done;
        logic slot_fires;
        logic out_busy;
    } t_sts;
endpackage

FILE: src/scaled_timer_table.sv
// Scaled timer table: a table of countdown timers with pause, step and scale ramp.
// Flow: an item is latched in idle; a non-tick op then goes from the divide state to the
// ack state, a tick runs the ramp divider (while a ramp is in progress), scale, slot walk
// and summary states. One item at a time: the next is taken in the cycle after the last
// result is loaded; a stalled result channel holds the walk and the final result.
// Reset: synchronous active-low; slots freed, scale 1.0, max_delta_us 100000.
module scaled_timer_table #(
    parameter int NUM_SLOTS = stt_pkg::NUM_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [23:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[3:0], elapsed_us[27:4], slot[31:28], duration_us[63:32], interval_us[95:64],
    // use_unscaled[96], scale_value[112:97], step_us[136:113], zero fill to 144
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fired_slot[3:0], scaled_delta_us[35:4], raw_delta_us[59:36], current_scale[75:60]
    output logic [79:0]  m_axis_tdata,
    // kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    logic [23:0] r_max_delta;
    stt_pkg::t_cmd cmd;
    stt_pkg::t_sts sts;
    logic [3:0]  fslot;
    logic [31:0] sc;
    logic [23:0] rw;
    logic [15:0] cs;

    // Hold the clamp register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delta <= stt_pkg::MAX_DELTA_RST;
        end else if (i_cfg_we) begin
            r_max_delta <= i_cfg_wdata;
        end
    end

    stt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .i_sts(sts), .o_cmd(cmd)
    );

    stt_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_max_delta(r_max_delta),
        .i_op(s_axis_tdata[3:0]), .i_elapsed_us(s_axis_tdata[27:4]),
        .i_slot(s_axis_tdata[31:28]), .i_duration_us(s_axis_tdata[63:32]),
        .i_interval_us(s_axis_tdata[95:64]), .i_use_unscaled(s_axis_tdata[96]),
        .i_scale_value(s_axis_tdata[112:97]), .i_step_us(s_axis_tdata[136:113]),
        .i_cmd(cmd), .o_sts(sts), .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid), .o_kind(m_axis_tuser), .o_fired_slot(fslot),
        .o_scaled_delta(sc), .o_raw_delta(rw), .o_current_scale(cs),
        .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, cs, rw, sc, fslot};

`ifndef ASSERT_OFF
    // A new item is never taken while a non-last result is pending in the output
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> !(m_axis_tvalid && !m_axis_tlast))
        else $error("item accepted mid-result");
    // Acknowledge results always close the item
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == stt_pkg::KIND_ACK |-> m_axis_tlast)
        else $error("ack without last");
    // Fired results never carry last
    a_fire_nolast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == stt_pkg::KIND_FIRED |-> !m_axis_tlast)
        else $error("fired result with last");
`endif
endmodule

FILE: src/stt_ctrl.sv
// Controller FSM for the scaled timer table.
// Depends on stt_pkg.
module stt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  stt_pkg::t_sts   i_sts,
    output stt_pkg::t_cmd   o_cmd
);
    stt_pkg::t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            stt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start_op = 1'b1;
                    n_state = stt_pkg::ST_DIV;
                end
            end
            stt_pkg::ST_DIV: begin
                if (!i_sts.is_tick) begin
                    n_state = stt_pkg::ST_ACK;
                end else if (i_sts.need_div) begin
                    if (i_sts.div_done) begin
                        n_state = stt_pkg::ST_SCALE;
                    end else begin
                        o_cmd.div_step = 1'b1;
                    end
                end else begin
                    n_state = stt_pkg::ST_SCALE;
                end
            end
            stt_pkg::ST_SCALE: begin
                o_cmd.scale_calc = 1'b1;
                n_state = stt_pkg::ST_WALK;
            end
            stt_pkg::ST_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = stt_pkg::ST_SUMMARY;
                end else if (!(i_sts.slot_fires && i_sts.out_busy)) begin
                    o_cmd.walk_step = 1'b1;
                    o_cmd.emit = i_sts.slot_fires;
                    o_cmd.kind = stt_pkg::KIND_FIRED;
                end
            end
            stt_pkg::ST_SUMMARY: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = stt_pkg::KIND_SUMMARY;
                    o_cmd.last = 1'b1;
                    n_state = stt_pkg::ST_IDLE;
                end
            end
            stt_pkg::ST_ACK: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = stt_pkg::KIND_ACK;
                    o_cmd.last = 1'b1;
                    n_state = stt_pkg::ST_IDLE;
                end
            end
            default: n_state = stt_pkg::ST_IDLE;
        endcase
    end
endmodule

FILE: src/stt_dp.sv
// Datapath for the scaled timer table: slot memory, ramp divider, output register.
// Depends on stt_pkg.
module stt_dp #(
    parameter int NUM_SLOTS = stt_pkg::NUM_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [23:0]     i_max_delta,
    input  logic [3:0]      i_op,
    input  logic [23:0]     i_elapsed_us,
    input  logic [3:0]      i_slot,
    input  logic [31:0]     i_duration_us,
    input  logic [31:0]     i_interval_us,
    input  logic            i_use_unscaled,
    input  logic [15:0]     i_scale_value,
    input  logic [23:0]     i_step_us,
    input  stt_pkg::t_cmd   i_cmd,
    output stt_pkg::t_sts   o_sts,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [1:0]      o_kind,
    output logic [3:0]      o_fired_slot,
    output logic [31:0]     o_scaled_delta,
    output logic [23:0]     o_raw_delta,
    output logic [15:0]     o_current_scale,
    output logic            o_last
);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [33:0] REM_MIN = 34'h2_0000_0000;

    // Slot tables
    logic [NUM_SLOTS-1:0] r_valid;
    logic [33:0] r_rem [NUM_SLOTS];
    logic [31:0] r_period [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_rawt;

    logic        r_paused;
    logic [31:0] r_budget;
    logic [15:0] r_scale;
    logic        r_ramp_on;
    logic [15:0] r_ramp_start, r_ramp_target;
    logic [31:0] r_ramp_len, r_ramp_el;

    logic        r_is_tick;
    logic        r_need_div;
    logic        r_use_scale;
    logic [23:0] r_raw;
    logic [31:0] r_scaled;
    logic [CW-1:0] r_idx;

    // Restoring divider: (diff * e) / len, 48-bit dividend
    logic [47:0] r_quo;
    logic [31:0] r_rem_d;
    logic [5:0]  r_div_cnt;
    logic        r_ramp_done;

    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [3:0]  r_fslot;
    logic [31:0] r_osc;
    logic [23:0] r_oraw;
    logic [15:0] r_oscale;
    logic        r_olast;

    logic [23:0] raw_clamp, raw_sel;
    logic [31:0] use_amt;
    logic [32:0] el_sum;
    logic [31:0] el_new;
    logic [15:0] diff;
    logic [32:0] rem_trial;
    logic [SW-1:0] widx;
    logic [33:0] cur_rem, sub_amt, rem_sub, rem_after;
    logic        sat, fires;
    logic [32:0] bud_sum;
    logic [15:0] scale_new;
    logic [39:0] scaled_prod;
    logic        slot_ok;

    always_comb begin
        raw_clamp = (i_elapsed_us < i_max_delta) ? i_elapsed_us : i_max_delta;
        use_amt = (r_budget < {8'd0, raw_clamp}) ? r_budget : {8'd0, raw_clamp};
        raw_sel = (r_paused && r_budget != 32'd0) ? use_amt[23:0] : raw_clamp;
        el_sum = {1'b0, r_ramp_el} + {9'd0, raw_sel};
        el_new = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
        diff = (r_ramp_target >= r_ramp_start) ? (r_ramp_target - r_ramp_start)
                                                : (r_ramp_start - r_ramp_target);
        rem_trial = {r_rem_d, r_quo[47]};
        widx = r_idx[SW-1:0];
        cur_rem = r_rem[widx];
        sub_amt = r_rawt[widx] ? {10'd0, r_raw} : {2'd0, r_scaled};
        rem_sub = cur_rem - sub_amt;
        // saturate when the signed result wrapped past the negative bound
        sat = cur_rem[33] && !rem_sub[33];
        rem_after = sat ? REM_MIN : rem_sub;
        fires = rem_after[33] || (rem_after == 34'd0);
        bud_sum = {1'b0, r_budget} + {9'd0, i_step_us};
        // scale after the ramp update of this tick
        scale_new = r_ramp_done ? r_ramp_target
                  : !r_need_div ? r_scale
                  : (r_ramp_target >= r_ramp_start) ? (r_ramp_start + r_quo[15:0])
                                                     : (r_ramp_start - r_quo[15:0]);
        scaled_prod = {16'd0, r_raw} * {24'd0, scale_new};
        slot_ok = ({28'd0, i_slot} < 32'(NUM_SLOTS));
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_paused <= 1'b0;
            r_budget <= '0;
            r_scale <= stt_pkg::SCALE_ONE;
            r_ramp_on <= 1'b0;
            r_ramp_start <= '0;
            r_ramp_target <= '0;
            r_ramp_len <= '0;
            r_ramp_el <= '0;
            r_out_valid <= 1'b0;
            r_is_tick <= 1'b0;
            r_need_div <= 1'b0;
            r_ramp_done <= 1'b0;
            r_div_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cmd.emit) r_out_valid <= 1'b1;
            if (i_cmd.start_op) begin
                r_is_tick <= (i_op == stt_pkg::OP_TICK);
                r_need_div <= 1'b0;
                r_ramp_done <= 1'b0;
                r_idx <= '0;
                r_div_cnt <= '0;
                unique case (i_op)
                    stt_pkg::OP_TICK: begin
                        if (!r_paused || r_budget != 32'd0) begin
                            if (r_paused) r_budget <= r_budget - use_amt;
                            if (r_ramp_on) begin
                                r_ramp_el <= el_new;
                                if (el_new >= r_ramp_len) begin
                                    r_ramp_on <= 1'b0;
                                    r_ramp_done <= 1'b1;
                                end else begin
                                    r_need_div <= 1'b1;
                                end
                            end
                        end
                    end
                    stt_pkg::OP_ADD: if (slot_ok) r_valid[i_slot[SW-1:0]] <= 1'b1;
                    stt_pkg::OP_CANCEL: if (slot_ok) r_valid[i_slot[SW-1:0]] <= 1'b0;
                    stt_pkg::OP_PAUSE: r_paused <= 1'b1;
                    stt_pkg::OP_RESUME: begin
                        r_paused <= 1'b0;
                        r_budget <= '0;
                    end
                    stt_pkg::OP_STEP: if (r_paused)
                        r_budget <= bud_sum[32] ? 32'hFFFF_FFFF : bud_sum[31:0];
                    stt_pkg::OP_SET_SCALE: r_scale <= i_scale_value;
                    stt_pkg::OP_SMOOTH: begin
                        r_ramp_start <= r_scale;
                        r_ramp_target <= i_scale_value;
                        r_ramp_len <= i_duration_us;
                        r_ramp_el <= '0;
                        r_ramp_on <= (i_duration_us != 32'd0);
                        if (i_duration_us == 32'd0) r_scale <= i_scale_value;
                    end
                    stt_pkg::OP_CANCEL_SMOOTH: r_ramp_on <= 1'b0;
                    default: ;
                endcase
            end
            if (i_cmd.div_step) r_div_cnt <= r_div_cnt + 6'd1;
            if (i_cmd.scale_calc) r_scale <= scale_new;
            if (i_cmd.walk_step) begin
                r_idx <= r_idx + CW'(1);
                if (r_valid[widx] && fires && r_period[widx] == 32'd0)
                    r_valid[widx] <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_op) begin
            r_raw <= (i_op == stt_pkg::OP_TICK) ? raw_sel : 24'd0;
            r_use_scale <= !r_paused || r_budget != 32'd0;
            if (r_ramp_on && !(el_new >= r_ramp_len)) begin
                r_quo <= {16'd0, diff} * {16'd0, el_new};
                r_rem_d <= '0;
            end
            if (i_op == stt_pkg::OP_ADD && slot_ok) begin
                r_rem[i_slot[SW-1:0]] <= {2'd0, i_duration_us};
                r_period[i_slot[SW-1:0]] <= i_interval_us;
                r_rawt[i_slot[SW-1:0]] <= i_use_unscaled;
            end
        end
        if (i_cmd.div_step) begin
            if (rem_trial >= {1'b0, r_ramp_len}) begin
                r_rem_d <= 32'(rem_trial - {1'b0, r_ramp_len});
                r_quo <= {r_quo[46:0], 1'b1};
            end else begin
                r_rem_d <= rem_trial[31:0];
                r_quo <= {r_quo[46:0], 1'b0};
            end
        end
        // Scaled delta uses the scale after the ramp update; zero while paused without budget
        if (i_cmd.scale_calc) r_scaled <= r_use_scale ? scaled_prod[39:8] : 32'd0;
        if (i_cmd.walk_step && r_valid[widx])
            r_rem[widx] <= (fires && r_period[widx] != 32'd0)
                           ? rem_after + {2'd0, r_period[widx]} : rem_after;
        if (i_cmd.emit) begin
            r_kind <= i_cmd.kind;
            r_fslot <= (i_cmd.kind == stt_pkg::KIND_FIRED) ? 4'(widx) : 4'd0;
            r_osc <= (i_cmd.kind == stt_pkg::KIND_ACK) ? 32'd0 : r_scaled;
            r_oraw <= (i_cmd.kind == stt_pkg::KIND_ACK) ? 24'd0 : r_raw;
            r_oscale <= r_scale;
            r_olast <= i_cmd.last;
        end
    end

    always_comb begin
        o_sts.is_tick = r_is_tick;
        o_sts.need_div = r_need_div;
        o_sts.div_done = (r_div_cnt == 6'd48);
        o_sts.walk_done = (r_idx == CW'(NUM_SLOTS));
        o_sts.slot_fires = r_valid[widx] && fires;
        o_sts.out_busy = r_out_valid && !i_out_ready;
        o_out_valid = r_out_valid;
        o_kind = r_kind;
        o_fired_slot = r_fslot;
        o_scaled_delta = r_osc;
        o_raw_delta = r_oraw;
        o_current_scale = r_oscale;
        o_last = r_olast;
    end
endmodule

FILE: bench/scaled_timer_table_check.sv
// Checker for the scaled timer table: watches both stream channels, predicts results
// from accepted input transfers and compares them field by field. Depends on stt_pkg.
`timescale 1ns / 1ps
module scaled_timer_table_check (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [23:0]  i_cfg_wdata,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [143:0] i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [79:0]  i_out_data,
    input  logic [1:0]   i_out_kind,
    input  logic         i_out_last,
    output int           o_errors,
    output int           o_pending
);
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  fslot;
        logic [31:0] scaled;
        logic [23:0] raw;
        logic [15:0] scale;
        logic        last;
    } t_result;

    localparam longint REM_FLOOR = -(64'sd1 <<< 33);

    t_result     want_q[$];
    logic [23:0] clamp_us;
    logic        busy_slot[16];
    longint      left_us[16];
    logic [31:0] period_us[16];
    logic        raw_clock[16];
    logic        paused;
    logic [31:0] budget;
    logic [15:0] scale;
    logic        ramping;
    logic [15:0] ramp_from, ramp_to;
    logic [31:0] ramp_len, ramp_done;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    function automatic t_result make(logic [1:0] k, logic [3:0] s, logic [31:0] sc,
                                     logic [23:0] r, logic l);
        t_result x;
        x.kind = k; x.fslot = s; x.scaled = sc; x.raw = r; x.scale = scale; x.last = l;
        return x;
    endfunction

    // Append one expected result at the tail
    task automatic enqueue(input t_result x);
        want_q.insert(want_q.size(), x);
    endtask

    // Advance the scale ramp by the raw delta
    task automatic ramp_advance(input logic [31:0] raw);
        longint e, len;
        e = longint'(ramp_done) + longint'(raw);
        if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
        len = (ramp_len != 32'd0) ? longint'(ramp_len) : 64'sd1;
        ramp_done = e[31:0];
        if (e >= len) begin
            scale = ramp_to;
            ramping = 1'b0;
        end else if (ramp_to >= ramp_from) begin
            scale = ramp_from + 16'(((longint'(ramp_to - ramp_from)) * e) / len);
        end else begin
            scale = ramp_from - 16'(((longint'(ramp_from - ramp_to)) * e) / len);
        end
    endtask

    // Count down every live slot and queue a fired result per expiry
    task automatic walk_slots(input logic [31:0] scaled, input logic [31:0] raw);
        longint r;
        for (int i = 0; i < 16; i++) begin
            if (!busy_slot[i]) continue;
            r = left_us[i] - (raw_clock[i] ? longint'(raw) : longint'(scaled));
            if (r < REM_FLOOR) r = REM_FLOOR;
            if (r <= 0) begin
                enqueue(make(stt_pkg::KIND_FIRED, 4'(i), scaled, raw[23:0], 1'b0));
                if (period_us[i] > 32'd0) r += longint'(period_us[i]);
                else busy_slot[i] = 1'b0;
            end
            left_us[i] = r;
        end
    endtask

    task automatic predict(input logic [143:0] d);
        stt_pkg::t_op op;
        logic [31:0]  raw, use_us, scaled;
        longint       sum;
        op = stt_pkg::t_op'(d[3:0]);
        if (op == stt_pkg::OP_TICK) begin
            raw = (d[27:4] < clamp_us) ? {8'd0, d[27:4]} : {8'd0, clamp_us};
            if (paused && budget == 32'd0) begin
                walk_slots(32'd0, raw);
                enqueue(make(stt_pkg::KIND_SUMMARY, 4'd0, 32'd0, raw[23:0], 1'b1));
                return;
            end
            if (paused) begin
                use_us = (budget < raw) ? budget : raw;
                budget -= use_us;
                raw = use_us;
            end
            if (ramping) ramp_advance(raw);
            scaled = 32'((longint'(raw) * longint'(scale)) >> 8);
            walk_slots(scaled, raw);
            enqueue(make(stt_pkg::KIND_SUMMARY, 4'd0, scaled, raw[23:0], 1'b1));
            return;
        end
        case (op)
            stt_pkg::OP_ADD: begin
                busy_slot[d[31:28]] = 1'b1;
                left_us[d[31:28]] = longint'(d[63:32]);
                period_us[d[31:28]] = d[95:64];
                raw_clock[d[31:28]] = d[96];
            end
            stt_pkg::OP_CANCEL: busy_slot[d[31:28]] = 1'b0;
            stt_pkg::OP_PAUSE: paused = 1'b1;
            stt_pkg::OP_RESUME: begin
                paused = 1'b0;
                budget = '0;
            end
            stt_pkg::OP_STEP: if (paused) begin
                sum = longint'(budget) + longint'(d[136:113]);
                budget = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end
            stt_pkg::OP_SET_SCALE: scale = d[112:97];
            stt_pkg::OP_SMOOTH: begin
                ramp_from = scale;
                ramp_to = d[112:97];
                ramp_len = d[63:32];
                ramp_done = '0;
                ramping = (d[63:32] != 32'd0);
                if (!ramping) scale = d[112:97];
            end
            stt_pkg::OP_CANCEL_SMOOTH: ramping = 1'b0;
            default: ;
        endcase
        enqueue(make(stt_pkg::KIND_ACK, 4'd0, 32'd0, 24'd0, 1'b1));
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_result got, exp;
        if (!i_rst_n) begin
            clamp_us <= stt_pkg::MAX_DELTA_RST;
            for (int i = 0; i < 16; i++) busy_slot[i] = 1'b0;
            paused = 1'b0; budget = '0; scale = stt_pkg::SCALE_ONE; ramping = 1'b0;
            ramp_from = '0; ramp_to = '0; ramp_len = '0; ramp_done = '0;
            want_q.delete();
        end else begin
            if (i_cfg_we) clamp_us <= i_cfg_wdata;
            if (i_in_valid && i_in_ready) predict(i_in_data);
            // Compare the result transfer with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                got = {i_out_kind, i_out_data[3:0], i_out_data[35:4], i_out_data[59:36],
                       i_out_data[75:60], i_out_last};
                if (want_q.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    exp = want_q.pop_front();
                    if (got.kind != exp.kind)
                        report($sformatf("kind %0d want %0d", got.kind, exp.kind));
                    if (got.fslot != exp.fslot)
                        report($sformatf("slot %0d want %0d", got.fslot, exp.fslot));
                    if (got.scaled != exp.scaled)
                        report($sformatf("scaled %0d want %0d", got.scaled, exp.scaled));
                    if (got.raw != exp.raw)
                        report($sformatf("raw %0d want %0d", got.raw, exp.raw));
                    if (got.scale != exp.scale)
                        report($sformatf("scale %0d want %0d", got.scale, exp.scale));
                    if (got.last != exp.last)
                        report($sformatf("last %0d want %0d", got.last, exp.last));
                end
            end
        end
        o_pending = want_q.size();
    end
endmodule

FILE: bench/scaled_timer_table_test.sv
// Testbench top for the scaled timer table: clock, reset, stimulus and verdict.
// Depends on stt_pkg, scaled_timer_table and scaled_timer_table_check.
`timescale 1ns / 1ps
module scaled_timer_table_test;
    localparam int CYCLE_LIMIT = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [23:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    int           errors, pending, cycles;
    logic         calm = 1'b0;

    always #4 i_clk = ~i_clk;

    scaled_timer_table uut (.*);

    scaled_timer_table_check checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_kind(m_axis_tuser), .i_out_last(m_axis_tlast),
        .o_errors(errors), .o_pending(pending)
    );

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stall the result channel in random bursts
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Send one input transfer, holding it until it is taken
    task automatic send(input stt_pkg::t_op op, input logic [23:0] el, input logic [3:0] s,
                        input logic [31:0] dur, input logic [31:0] iv, input logic u,
                        input logic [15:0] sv, input logic [23:0] st);
        int   n;
        logic took;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 11);
            repeat (n) @(negedge i_clk);
        end
        s_axis_tdata <= {7'd0, st, sv, u, iv, dur, s, el, op};
        s_axis_tvalid <= 1'b1;
        // tready only moves at rising edges, so its value here decides the next edge
        do begin
            took = s_axis_tready;
            @(negedge i_clk);
        end while (!took);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_clamp(input logic [23:0] v);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 400000);
        endcase
    endfunction

    function automatic logic [23:0] pick24();
        case ($urandom_range(0, 4))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2: return 24'($urandom);
            default: return 24'($urandom_range(0, 150000));
        endcase
    endfunction

    // One random item, weighted toward ticks and well-formed timers
    task automatic random_item();
        int w;
        w = $urandom_range(0, 99);
        if (w < 45)
            send(stt_pkg::OP_TICK, pick24(), 4'($urandom), $urandom, $urandom,
                 1'($urandom), 16'($urandom), 24'($urandom));
        else if (w < 65)
            send(stt_pkg::OP_ADD, 24'($urandom), 4'($urandom), pick32(),
                 ($urandom_range(0, 2) == 0) ? 32'd0 : pick32(), 1'($urandom),
                 16'($urandom), 24'($urandom));
        else if (w < 70)
            send(stt_pkg::OP_CANCEL, 24'($urandom), 4'($urandom), $urandom, $urandom,
                 1'($urandom), 16'($urandom), 24'($urandom));
        else if (w < 74) send(stt_pkg::OP_PAUSE, '0, '0, '0, '0, '0, '0, '0);
        else if (w < 79) send(stt_pkg::OP_RESUME, '0, '0, '0, '0, '0, '0, '0);
        else if (w < 85) send(stt_pkg::OP_STEP, '0, '0, '0, '0, '0, '0, pick24());
        else if (w < 89) send(stt_pkg::OP_SET_SCALE, '0, '0, '0, '0, '0, 16'($urandom), '0);
        else if (w < 95)
            send(stt_pkg::OP_SMOOTH, '0, '0, pick32(), '0, '0, 16'($urandom), '0);
        else if (w < 97) send(stt_pkg::OP_CANCEL_SMOOTH, '0, '0, '0, '0, '0, '0, '0);
        else send(stt_pkg::t_op'(4'($urandom_range(9, 15))), 24'($urandom), 4'($urandom),
                  $urandom, $urandom, 1'($urandom), 16'($urandom), 24'($urandom));
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every op and the special cases
        send(stt_pkg::OP_ADD, '0, 4'd0, 32'd0, 32'd0, 1'b0, '0, '0);             // zero duration
        send(stt_pkg::OP_ADD, '0, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0, '0);
        send(stt_pkg::OP_ADD, '0, 4'd3, 32'd50000, 32'd20000, 1'b0, '0, '0);
        send(stt_pkg::OP_ADD, '0, 4'd3, 32'd10, 32'd30000, 1'b1, '0, '0);        // overwrite
        send(stt_pkg::OP_TICK, 24'hFF_FFFF, '0, '0, '0, '0, '0, '0);             // clamped
        send(stt_pkg::OP_TICK, 24'd0, '0, '0, '0, '0, '0, '0);
        send(stt_pkg::OP_CANCEL, '0, 4'd7, '0, '0, '0, '0, '0);                  // already free
        send(stt_pkg::OP_STEP, '0, '0, '0, '0, '0, '0, 24'd5000);                // running
        send(stt_pkg::OP_PAUSE, '0, '0, '0, '0, '0, '0, '0);
        send(stt_pkg::OP_TICK, 24'd40000, '0, '0, '0, '0, '0, '0);               // no budget
        send(stt_pkg::OP_STEP, '0, '0, '0, '0, '0, '0, 24'hFF_FFFF);
        send(stt_pkg::OP_STEP, '0, '0, '0, '0, '0, '0, 24'd7000);
        send(stt_pkg::OP_TICK, 24'd30000, '0, '0, '0, '0, '0, '0);               // budget
        send(stt_pkg::OP_RESUME, '0, '0, '0, '0, '0, '0, '0);
        send(stt_pkg::OP_SET_SCALE, '0, '0, '0, '0, '0, 16'hFFFF, '0);
        send(stt_pkg::OP_TICK, 24'd100000, '0, '0, '0, '0, '0, '0);
        send(stt_pkg::OP_SMOOTH, '0, '0, 32'd0, '0, '0, 16'd128, '0);            // zero duration
        send(stt_pkg::OP_SMOOTH, '0, '0, 32'd250000, '0, '0, 16'd1024, '0);      // ramp up
        send(stt_pkg::OP_TICK, 24'd90000, '0, '0, '0, '0, '0, '0);
        send(stt_pkg::OP_SMOOTH, '0, '0, 32'd300000, '0, '0, 16'd0, '0);        // ramp down
        send(stt_pkg::OP_TICK, 24'd80000, '0, '0, '0, '0, '0, '0);
        send(stt_pkg::OP_CANCEL_SMOOTH, '0, '0, '0, '0, '0, '0, '0);
        send(stt_pkg::OP_CANCEL, '0, 4'd15, '0, '0, '0, '0, '0);
        send(stt_pkg::t_op'(4'd15), 24'hFF_FFFF, 4'hF, '1, '1, 1'b1, '1, '1);   // undefined op

        // Random phases at several clamp settings
        write_clamp(24'd1);
        repeat (50) random_item();
        write_clamp(24'hFF_FFFF);
        repeat (55) random_item();
        write_clamp(24'd100000);
        repeat (55) random_item();
        write_clamp(24'($urandom_range(1000, 200000)));
        repeat (50) random_item();
        calm = 1'b1;
        repeat (50) random_item();

        settle();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
